### design/general_and_hblank_vram_dma_unit_assert.svh
// Assertion macros for the VRAM DMA unit.
`ifndef GENERAL_AND_HBLANK_VRAM_DMA_UNIT_ASSERT_SVH
`define GENERAL_AND_HBLANK_VRAM_DMA_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define GVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/gvd_pkg.sv
`default_nettype none
package gvd_pkg;

    localparam int BLOCK_CYCLES = 32;
    localparam int BLOCK_BYTES  = 16;
    localparam int Q_DEPTH      = 4;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_TICK   = 2'd2,
        OP_HBLANK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_GENERAL = 2'd1,
        MODE_HBLANK  = 2'd2
    } t_mode;

    localparam logic [2:0] REG_SRC_HI = 3'd0;
    localparam logic [2:0] REG_SRC_LO = 3'd1;
    localparam logic [2:0] REG_DST_HI = 3'd2;
    localparam logic [2:0] REG_DST_LO = 3'd3;
    localparam logic [2:0] REG_CTRL   = 3'd4;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_COPY = 1'b1;

    // One queued job: a read reply or a whole block of copies.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] src;
        logic [12:0] dst;
    } t_cmd;

endpackage
`default_nettype wire

### design/gvd_front.sv
`default_nettype none
module gvd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [1:0]    i_operation,
    input  wire logic [2:0]    i_reg_index,
    input  wire logic [7:0]    i_write_data,
    input  wire logic          i_in_hblank,
    input  wire logic          i_cpu_halted,
    input  wire logic [2:0]    i_tcycles_this_tick,
    output logic               o_push,
    output gvd_pkg::t_cmd      o_cmd
);
    localparam logic [6:0] BlockCyc = 7'(gvd_pkg::BLOCK_CYCLES);
    localparam logic [15:0] BlockLen = 16'(gvd_pkg::BLOCK_BYTES);

    logic [15:0]    r_src, n_src;
    logic [15:0]    r_dst, n_dst;
    logic [7:0]     r_blocks, n_blocks;
    gvd_pkg::t_mode r_mode, n_mode;
    logic           r_active, n_active;
    logic [5:0]     r_acc, n_acc;

    logic [6:0]     sum, sum_adj;
    logic           fire;
    logic [7:0]     blocks_dec;
    logic [15:0]    dst_next;
    gvd_pkg::t_op   op;

    assign op         = gvd_pkg::t_op'(i_operation);
    assign sum        = {1'b0, r_acc} + {4'b0, i_tcycles_this_tick};
    assign fire       = (sum >= BlockCyc);
    assign sum_adj    = fire ? (sum - BlockCyc) : sum;
    assign blocks_dec = r_blocks - 8'd1;
    assign dst_next   = r_dst + BlockLen;

    always_comb begin
        n_src    = r_src;
        n_dst    = r_dst;
        n_blocks = r_blocks;
        n_mode   = r_mode;
        n_active = r_active;
        n_acc    = r_acc;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (i_accept) begin
            unique case (op)
                gvd_pkg::OP_WRITE: begin
                    unique case (i_reg_index)
                        gvd_pkg::REG_SRC_HI: n_src[15:8] = i_write_data;
                        gvd_pkg::REG_SRC_LO: n_src[7:0]  = i_write_data & 8'hF0;
                        gvd_pkg::REG_DST_HI: n_dst[15:8] = i_write_data;
                        gvd_pkg::REG_DST_LO: n_dst[7:0]  = i_write_data & 8'hF0;
                        gvd_pkg::REG_CTRL: begin
                            n_blocks = {1'b0, i_write_data[6:0]};
                            if (r_mode != gvd_pkg::MODE_NONE) begin
                                if (!i_write_data[7]) begin
                                    n_mode   = gvd_pkg::MODE_NONE;
                                    n_active = 1'b0;
                                end
                            end else begin
                                n_acc = '0;
                                if (i_write_data[7]) begin
                                    n_mode   = gvd_pkg::MODE_HBLANK;
                                    n_active = i_in_hblank;
                                end else begin
                                    n_mode   = gvd_pkg::MODE_GENERAL;
                                    n_active = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                gvd_pkg::OP_READ: begin
                    o_push     = 1'b1;
                    o_cmd.kind = gvd_pkg::KIND_READ;
                    o_cmd.data = (i_reg_index == gvd_pkg::REG_CTRL) ?
                                 {(r_mode == gvd_pkg::MODE_NONE), r_blocks[6:0]} : 8'hFF;
                end
                gvd_pkg::OP_TICK: begin
                    if (r_active && !i_cpu_halted) begin
                        if (fire) begin
                            o_push     = 1'b1;
                            o_cmd.kind = gvd_pkg::KIND_COPY;
                            o_cmd.src  = r_src;
                            o_cmd.dst  = r_dst[12:0];
                            n_src      = r_src + BlockLen;
                            n_dst      = dst_next;
                            n_blocks   = blocks_dec;
                            if (blocks_dec == 8'hFF || dst_next == 16'h0000) begin
                                n_mode   = gvd_pkg::MODE_NONE;
                                n_active = 1'b0;
                            end else if (r_mode == gvd_pkg::MODE_HBLANK) begin
                                n_active = 1'b0;
                            end
                        end
                        n_acc = (sum_adj > 7'd63) ? 6'd63 : sum_adj[5:0];
                    end
                end
                gvd_pkg::OP_HBLANK: begin
                    if (r_mode == gvd_pkg::MODE_HBLANK && !r_active) begin
                        n_active = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src    <= '0;
            r_dst    <= '0;
            r_blocks <= '0;
            r_mode   <= gvd_pkg::MODE_NONE;
            r_active <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_src    <= n_src;
            r_dst    <= n_dst;
            r_blocks <= n_blocks;
            r_mode   <= n_mode;
            r_active <= n_active;
            r_acc    <= n_acc;
        end
    end
endmodule
`default_nettype wire

### design/gvd_queue.sv
`default_nettype none
module gvd_queue #(
    parameter int DEPTH = gvd_pkg::Q_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gvd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output gvd_pkg::t_cmd      o_head,
    output logic               o_empty,
    output logic               o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] Full    = CW'(DEPTH);

    gvd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == Full);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastIdx) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastIdx) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

### design/gvd_back.sv
`default_nettype none
module gvd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gvd_pkg::t_cmd i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic               o_result_kind,
    output logic [7:0]         o_read_data,
    output logic [15:0]        o_copy_source,
    output logic [12:0]        o_copy_dest,
    output logic               o_last_of_block
);
    localparam int BW = $clog2(gvd_pkg::BLOCK_BYTES);
    localparam logic [BW-1:0] LastBeat = BW'(gvd_pkg::BLOCK_BYTES - 1);

    gvd_pkg::t_cmd r_ent;
    logic          r_busy;
    logic [BW-1:0] r_beat;
    logic          take, done;

    assign take  = r_busy && !i_stall;
    assign done  = take && (r_ent.kind == gvd_pkg::KIND_READ || r_beat == LastBeat);
    assign o_pop = (!r_busy || done) && !i_empty;

    assign o_valid       = r_busy;
    assign o_result_kind = r_ent.kind;
    always_comb begin
        if (r_ent.kind == gvd_pkg::KIND_COPY) begin
            o_read_data     = '0;
            o_copy_source   = r_ent.src + 16'(r_beat);
            o_copy_dest     = r_ent.dst + 13'(r_beat);
            o_last_of_block = (r_beat == LastBeat);
        end else begin
            o_read_data     = r_ent.data;
            o_copy_source   = '0;
            o_copy_dest     = '0;
            o_last_of_block = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_beat <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_beat <= r_beat + BW'(1);
        end
    end
endmodule
`default_nettype wire

### design/general_and_hblank_vram_dma_unit.sv
// Channel | Direction | Handshake          | Beat
// in      | in        | i_valid / o_stall  | one bus item: write, read, tick, hblank
// out     | out       | o_valid / i_stall  | one read reply or one byte copy
//
// An item is taken every cycle while the command queue has room.
// A read costs one out beat; a tick that completes a block queues a job that
// the back end plays out as 16 beats, one per cycle while i_stall is low, so
// sustained tick rate is bounded by the 16-beat drain of each block through the
// single output port. Reset is synchronous.
// o_stall rises only when the queue is full; out stalls freeze the beat counter.
`default_nettype none
`include "general_and_hblank_vram_dma_unit_assert.svh"
module general_and_hblank_vram_dma_unit #(
    parameter int Q_DEPTH = gvd_pkg::Q_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [2:0]  i_reg_index,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_in_hblank,
    input  wire logic        i_cpu_halted,
    input  wire logic [2:0]  i_tcycles_this_tick,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_result_kind,
    output logic [7:0]       o_read_data,
    output logic [15:0]      o_copy_source,
    output logic [12:0]      o_copy_dest,
    output logic             o_last_of_block
);
    gvd_pkg::t_cmd push_cmd, head;
    logic          push, pop, q_empty, q_full, in_acc;

    assign o_stall = q_full;
    assign in_acc  = i_valid && !q_full;

    gvd_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (in_acc),
        .i_operation         (i_operation),
        .i_reg_index         (i_reg_index),
        .i_write_data        (i_write_data),
        .i_in_hblank         (i_in_hblank),
        .i_cpu_halted        (i_cpu_halted),
        .i_tcycles_this_tick (i_tcycles_this_tick),
        .o_push              (push),
        .o_cmd               (push_cmd)
    );

    gvd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    gvd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_read_data     (o_read_data),
        .o_copy_source   (o_copy_source),
        .o_copy_dest     (o_copy_dest),
        .o_last_of_block (o_last_of_block)
    );

    // a block keeps going until its last beat is taken
    `GVD_ASSERT_NEXT(a_block_continues, i_clk, i_rst_n, o_valid && !i_stall && o_result_kind && !o_last_of_block, o_valid && o_result_kind, "block cut short")
    `GVD_ASSERT_NOW(a_last_only_on_copy, i_clk, i_rst_n, o_valid && o_last_of_block, o_result_kind, "last flag on read reply")
    `GVD_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, push, !q_full, "push into full queue")
endmodule
`default_nettype wire
